FILE: sv/assert_macros.svh
// Assertion helpers for the property checker in sv/psfc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, gated off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/psfc_pkg.sv
package psfc_pkg;

    // field widths
    localparam int STATUS_W  = 8;
    localparam int RAW_W     = 16;
    localparam int CFG_P_W   = 28;
    localparam int MODE_W    = 2;
    localparam int DENS_W    = 11;
    localparam int P_W       = 30;
    localparam int T_W       = 15;
    localparam int D_W       = 28;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 2;

    // depth divider: |p - atm| * 1e8 < 2^57, density * g < 2^31
    localparam int DIV_NUM_W = 57;
    localparam int DIV_DEN_W = 31;

    // status check
    localparam logic [STATUS_W-1:0] STATUS_MASK = 8'hDC;
    localparam logic [STATUS_W-1:0] STATUS_GOOD = 8'h40;

    // conversion constants
    localparam logic signed [31:0] RAW_ZERO    = 32'sd16384;
    localparam logic signed [33:0] ATM_PA      = 34'sd101325;
    localparam logic signed [33:0] SEALED_PA   = 34'sd100000;
    localparam logic signed [31:0] G_SCALED    = 32'sd980665;
    localparam logic signed [31:0] DEPTH_SCALE = 32'sd100000000;
    localparam logic signed [15:0] TEMP_BASE   = 16'sd5120;

    // gauge modes
    localparam logic [MODE_W-1:0] MODE_VENTED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEALED = 2'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_P   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_P   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 2'd3;

    // divider handshake
    typedef struct packed {
        logic start;
    } div_cmd_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

FILE: sv/psfc_div.sv
module psfc_div #(
    parameter int NUM_W = psfc_pkg::DIV_NUM_W,
    parameter int DEN_W = psfc_pkg::DIV_DEN_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psfc_pkg::div_cmd_t    cmd,
    input  logic [NUM_W-1:0]      dividend,
    input  logic [DEN_W-1:0]      divisor,
    output psfc_pkg::div_stat_t   stat,
    output logic [NUM_W-1:0]      quotient
);
    import psfc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // one restoring step per cycle, quotient bits shift in from the bottom
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            den_reg <= divisor;
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

FILE: sv/pressure_sensor_frame_convert_core.sv
// Pressure sensor frame converter.
// Input stream (s_*): one word per sensor frame, status byte, raw pressure and
// raw temperature. Output stream (m_*): one word per frame, pressure in Pa,
// temperature in 0.01 C, depth in mm, with m_tuser = 1 when the status passed.
// A frame with a bad status returns m_tuser = 0 and the last good values.
// Config port (cfg_*): index 0 min Pa, 1 max Pa, 2 gauge mode, 3 density;
// cfg_ready is always high; write only while no frame is in flight.
// Sequence: a good frame goes through the shared multiplier passes and the
// 57-step restoring divider for depth before m_tvalid; with density 0 the
// divider is skipped; a bad frame goes straight to the output state. One
// frame is in flight at a time, so a new frame is taken only once the last
// result has moved into the output register.
// Output is a single register: a new frame may be accepted while a finished
// result waits; if m_tready stays low, the next result holds in its last step
// until the output register frees.
// Reset (rst_n, async, active low) restores the default config and zeroes the
// last good values; the output is empty after reset.
module pressure_sensor_frame_convert_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // [7:0] status_byte, [23:8] raw_pressure, [39:24] raw_temperature
    input  logic [psfc_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [29:0] pressure_pa, [44:30] temperature_centi_c, [72:45] depth_mm, rest 0
    output logic [psfc_pkg::OUT_DATA_W-1:0]       m_tdata,
    // [0] frame_valid
    output logic                                  m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psfc_pkg::CFG_P_W-1:0]          cfg_data
);
    import psfc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_P = 3'd1;  // raw offset * span
    localparam logic [2:0] ST_PRES  = 3'd2;  // shift, add offsets, saturate
    localparam logic [2:0] ST_MUL_N = 3'd3;  // |p - atm| * 1e8
    localparam logic [2:0] ST_MUL_D = 3'd4;  // density * g, start divider if density is nonzero
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;  // sign, saturate, store last good
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic signed [33:0] P_HI  = 34'sd536870911;
    localparam logic signed [33:0] P_LO  = -34'sd536870912;
    localparam logic [DIV_NUM_W-1:0] D_POS_MAX = DIV_NUM_W'(134217727);
    localparam logic [DIV_NUM_W-1:0] D_NEG_MAX = DIV_NUM_W'(134217728);

    // config
    logic signed [CFG_P_W-1:0] min_p_reg;
    logic signed [CFG_P_W-1:0] max_p_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic [DENS_W-1:0]         dens_reg;

    // sequencer and working registers
    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic                      ok_reg;
    logic [RAW_W-1:0]          rawp_reg;
    logic [11:0]               rawt_reg;
    logic signed [63:0]        prod_reg;
    logic signed [P_W-1:0]     p_reg;
    logic                      neg_reg;

    // last good values
    logic signed [P_W-1:0]     last_p_reg;
    logic signed [T_W-1:0]     last_t_reg;
    logic signed [D_W-1:0]     last_d_reg;

    // output register
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic                      m_tuser_reg;

    // shared multiplier
    logic signed [31:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [63:0]        mul_p;

    logic                      s_fire;
    logic                      out_free;
    logic                      status_ok;
    logic signed [33:0]        p_offset;
    logic signed [33:0]        p_sum;
    logic signed [P_W-1:0]     p_sat;
    logic signed [31:0]        atm_diff;
    logic [31:0]               atm_mag;
    logic signed [15:0]        temp_calc;
    logic signed [D_W-1:0]     d_calc;

    div_cmd_t                  div_cmd;
    div_stat_t                 div_stat;
    logic [DIV_NUM_W-1:0]      div_q;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign status_ok = (s_tdata[7:0] & STATUS_MASK) == STATUS_GOOD;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_p_reg <= '0;
            max_p_reg <= CFG_P_W'(1000000);
            mode_reg  <= MODE_VENTED;
            dens_reg  <= DENS_W'(1029);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_P:   min_p_reg <= cfg_data;
                CFG_MAX_P:   max_p_reg <= cfg_data;
                CFG_MODE:    mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_DENSITY: dens_reg  <= cfg_data[DENS_W-1:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_P:
            begin
                mul_a = $signed({16'b0, rawp_reg}) - RAW_ZERO;
                mul_b = 32'(max_p_reg) - 32'(min_p_reg);
            end
            ST_MUL_N:
            begin
                mul_a = $signed(atm_mag);
                mul_b = DEPTH_SCALE;
            end
            ST_MUL_D:
            begin
                mul_a = $signed({21'b0, dens_reg});
                mul_b = G_SCALED;
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // pressure: floor divide by 32768 is an arithmetic shift
    always_comb
    begin
        case (mode_reg)
            MODE_VENTED: p_offset = ATM_PA;
            MODE_SEALED: p_offset = SEALED_PA;
            default:     p_offset = '0;
        endcase
        p_sum = 34'($signed(prod_reg[47:15])) + 34'(min_p_reg) + p_offset;
        if (p_sum > P_HI)
            p_sat = P_W'(P_HI);
        else if (p_sum < P_LO)
            p_sat = P_W'(P_LO);
        else
            p_sat = p_sum[P_W-1:0];
    end

    assign atm_diff = 32'(p_reg) - 32'(ATM_PA);
    assign atm_mag  = atm_diff[31] ? 32'(-atm_diff) : 32'(atm_diff);

    // temperature: 5 * (raw >> 4) - 5120
    assign temp_calc = $signed({4'b0, rawt_reg}) * 16'sd5 - TEMP_BASE;

    // depth: apply sign, saturate to 28 bits
    always_comb
    begin
        if (dens_reg == '0)
            d_calc = '0;
        else if (!neg_reg)
            d_calc = (div_q > D_POS_MAX) ? D_W'(D_POS_MAX) : D_W'(div_q);
        else
            d_calc = (div_q > D_NEG_MAX) ? D_W'(-D_NEG_MAX) : D_W'(-div_q);
    end

    assign div_cmd.start = (state_reg == ST_MUL_D) && (dens_reg != '0);

    psfc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (prod_reg[DIV_NUM_W-1:0]),
        .divisor  (mul_p[DIV_DEN_W-1:0]),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) state_next = status_ok ? ST_MUL_P : ST_OUT;
            ST_MUL_P: state_next = ST_PRES;
            ST_PRES:  state_next = ST_MUL_N;
            ST_MUL_N: state_next = ST_MUL_D;
            ST_MUL_D: state_next = (dens_reg == '0) ? ST_FIN : ST_DIV;
            ST_DIV:   if (div_stat.done) state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            last_p_reg   <= '0;
            last_t_reg   <= '0;
            last_d_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN)
            begin
                last_p_reg <= p_reg;
                last_t_reg <= temp_calc[T_W-1:0];
                last_d_reg <= d_calc;
            end
            if (state_reg == ST_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            ok_reg   <= status_ok;
            rawp_reg <= s_tdata[23:8];
            rawt_reg <= s_tdata[39:28];
        end
        if (state_reg == ST_MUL_P || state_reg == ST_MUL_N)
            prod_reg <= mul_p;
        if (state_reg == ST_PRES)
            p_reg <= p_sat;
        if (state_reg == ST_MUL_N)
            neg_reg <= atm_diff[31];
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {7'b0, last_d_reg, last_t_reg, last_p_reg};
            m_tuser_reg <= ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/psfc_checker.sv
`include "assert_macros.svh"

module psfc_core_props (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [psfc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               m_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready
);
    import psfc_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // one frame at a time: busy right after taking a frame
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // a result appears just as the sequencer returns to idle
    `ASSERT_IMPLIES(a_idle_on_result, clk, rst_n, $rose(m_tvalid), s_tready)

    // padding bits above depth stay zero
    `ASSERT_IMPLIES(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[OUT_DATA_W-1:73] == '0)

endmodule

bind pressure_sensor_frame_convert_core psfc_core_props u_psfc_core_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

FILE: tb/psfc_checker.sv
`timescale 1ns / 100ps

// Watches the frame, result and register channels of the converter.
// Keeps its own copy of the register file and the last good readings,
// predicts one result word per accepted frame and compares in order.
module psfc_checker
    import psfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_P_W-1:0]    cfg_data,
    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic                  frame_ok;
        logic signed [P_W-1:0] pressure;
        logic signed [T_W-1:0] temp;
        logic signed [D_W-1:0] depth;
    } conv_result_t;

    conv_result_t expected_results[$];

    // register shadow
    longint              range_lo_pa;
    longint              range_hi_pa;
    logic [MODE_W-1:0]   mode;
    logic [DENS_W-1:0]   density;

    // last good readings
    logic signed [P_W-1:0] good_pressure;
    logic signed [T_W-1:0] good_temp;
    logic signed [D_W-1:0] good_depth;

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic conv_result_t convert_frame(logic [IN_DATA_W-1:0] frame);
        logic [STATUS_W-1:0] status;
        longint              rawp;
        longint              rawt;
        longint              offset;
        longint              p;
        longint              t;
        longint              d;
        conv_result_t        r;
        status     = frame[7:0];
        rawp       = frame[23:8];
        rawt       = frame[39:24];
        r.frame_ok = (status & STATUS_MASK) == STATUS_GOOD;
        r.pressure = good_pressure;
        r.temp     = good_temp;
        r.depth    = good_depth;
        if (r.frame_ok) begin
            if (mode == MODE_VENTED)
                offset = ATM_PA;
            else if (mode == MODE_SEALED)
                offset = SEALED_PA;
            else
                offset = 0;
            // arithmetic shift = floor division by 32768, negatives included
            p = (((rawp - RAW_ZERO) * (range_hi_pa - range_lo_pa)) >>> 15)
                + range_lo_pa + offset;
            p = clamp_signed(p, P_W);
            t = ((rawt >>> 4) - 24) * 5 - 5000;
            if (density == 0)
                d = 0;
            else
                d = clamp_signed(((p - ATM_PA) * DEPTH_SCALE) /
                                 (longint'(density) * G_SCALED), D_W);
            r.pressure = p[P_W-1:0];
            r.temp     = t[T_W-1:0];
            r.depth    = d[D_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        conv_result_t got;
        conv_result_t want;
        if (!rst_n) begin
            expected_results.delete();
            range_lo_pa   = 0;
            range_hi_pa   = 1000000;
            mode          = MODE_VENTED;
            density       = 11'd1029;
            good_pressure = '0;
            good_temp     = '0;
            good_depth    = '0;
            mismatches    = 0;
            pending       = 0;
        end
        else begin
            // result side first: an item offered this edge can't be out yet
            if (m_tvalid && m_tready) begin
                got.frame_ok = m_tuser;
                got.pressure = m_tdata[29:0];
                got.temp     = m_tdata[44:30];
                got.depth    = m_tdata[72:45];
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word ok=%0d p=%0d t=%0d d=%0d",
                                 $realtime, got.frame_ok, got.pressure, got.temp,
                                 got.depth);
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.frame_ok !== want.frame_ok || got.pressure !== want.pressure ||
                        got.temp !== want.temp || got.depth !== want.depth) begin
                        if (mismatches < 10)
                            $display("%0t: result differs: expected ok=%0d p=%0d t=%0d d=%0d, got ok=%0d p=%0d t=%0d d=%0d",
                                     $realtime, want.frame_ok, want.pressure, want.temp,
                                     want.depth, got.frame_ok, got.pressure, got.temp,
                                     got.depth);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = convert_frame(s_tdata);
                expected_results.push_back(want);
                if (want.frame_ok) begin
                    good_pressure = want.pressure;
                    good_temp     = want.temp;
                    good_depth    = want.depth;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_P:   range_lo_pa = $signed(cfg_data);
                    CFG_MAX_P:   range_hi_pa = $signed(cfg_data);
                    CFG_MODE:    mode        = cfg_data[MODE_W-1:0];
                    CFG_DENSITY: density     = cfg_data[DENS_W-1:0];
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Top of the converter bench. Makes the stimulus, owns the clock and reset,
// and gives the verdict. Prediction and comparison live in psfc_checker.
module tb;
    import psfc_pkg::*;

    // gauge modes without an offset, both treated as absolute
    localparam logic [MODE_W-1:0] MODE_ABS_A = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ABS_B = 2'd3;

    // 28-bit signed range ends
    localparam logic [CFG_P_W-1:0] PA_MOST_NEG = 28'h8000000;
    localparam logic [CFG_P_W-1:0] PA_MOST_POS = 28'h7FFFFFF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_P_W-1:0]    cfg_data;

    int mismatches;
    int pending;

    // idle_on: both sides insert random idle cycles (about 29 in 100)
    // stall_req: ask the receiver for one long hold-off
    bit idle_on;
    bit stall_req;

    always #1 clk = ~clk;

    pressure_sensor_frame_convert_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psfc_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Hard stop. A correct run needs about a tenth of this at most, even with
    // every good frame waiting on the divider, random gaps and the long hold-off.
    initial
    begin : run_limit
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Result side. Random back-pressure, plus one long hold-off counted here
    // so the block fills its output register and stops taking frames.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                hold_left = 3000;
                stall_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < 29);
        end
    end

    // Offer one frame word and wait until it is taken. Called at a clock edge
    // and returns at the accepting edge with s_tvalid still high, so the next
    // call (or drain) makes the only assignment to s_tvalid in that step.
    task automatic send_frame(input logic [STATUS_W-1:0] status,
                              input logic [RAW_W-1:0] rawp,
                              input logic [RAW_W-1:0] rawt);
        while (idle_on && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rawt, rawp, status};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mostly good frames with random content; the rest is any status at all.
    task automatic send_random_frame();
        logic [31:0]         r;
        logic [STATUS_W-1:0] status;
        logic [RAW_W-1:0]    rawp;
        r = $urandom;
        if ($urandom_range(99) < 70)
            status = STATUS_GOOD | (r[7:0] & ~STATUS_MASK);
        else
            status = r[7:0];
        case ($urandom_range(9))
            0:       rawp = 16'd16384;   // range minimum
            1:       rawp = 16'd49152;   // range maximum
            2:       rawp = 16'd0;
            3:       rawp = 16'hFFFF;
            default: rawp = r[31:16];
        endcase
        r = $urandom;
        send_frame(status, rawp, r[15:0]);
    endtask

    // Stop offering and wait until every predicted word has come out. Every
    // frame yields a word, so nothing is left in flight after that.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write all four registers back to back, only while the block is idle.
    task automatic apply_setting(input logic [CFG_P_W-1:0] lo_pa,
                                 input logic [CFG_P_W-1:0] hi_pa,
                                 input logic [MODE_W-1:0]  mode,
                                 input logic [DENS_W-1:0]  dens);
        logic [CFG_P_W-1:0]   vals [4];
        logic [CFG_IDX_W-1:0] idx  [4];
        vals[0] = lo_pa;             idx[0] = CFG_MIN_P;
        vals[1] = hi_pa;             idx[1] = CFG_MAX_P;
        vals[2] = CFG_P_W'(mode);    idx[2] = CFG_MODE;
        vals[3] = CFG_P_W'(dens);    idx[3] = CFG_DENSITY;
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Half full-width random range ends, half typical sensor ranges.
    task automatic apply_random_setting();
        logic [CFG_P_W-1:0] lo_pa;
        logic [CFG_P_W-1:0] hi_pa;
        logic [31:0]        r;
        logic [DENS_W-1:0]  dens;
        if ($urandom_range(1))
        begin
            r = $urandom;
            lo_pa = r[CFG_P_W-1:0];
            r = $urandom;
            hi_pa = r[CFG_P_W-1:0];
        end
        else
        begin
            lo_pa = CFG_P_W'(int'($urandom_range(200000000)) - 100000000);
            hi_pa = CFG_P_W'(int'($urandom_range(200000000)) - 100000000);
        end
        if ($urandom_range(3) == 0)
            dens = DENS_W'($urandom_range(2047));
        else
            dens = DENS_W'($urandom_range(2000, 500));
        apply_setting(lo_pa, hi_pa, MODE_W'($urandom_range(3)), dens);
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_P;
        cfg_data  = '0;
        idle_on   = 1'b1;
        stall_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset config ---
        // bad frame first: repeats the zeroed last-good values
        send_frame(8'h00, 16'd16384, 16'h0000);
        send_frame(STATUS_GOOD, 16'd16384, 16'h0000);   // range min, coldest
        send_frame(STATUS_GOOD, 16'd49152, 16'hFFFF);   // range max, hottest
        // don't-care status bits set; raw below range min -> negative product
        send_frame(8'h63, 16'd0, 16'h8000);
        send_frame(8'hFF, 16'hFFFF, 16'hFFFF);          // bad, all ones
        send_frame(STATUS_GOOD, 16'hFFFF, 16'h0180);
        send_frame(STATUS_MASK, 16'h1234, 16'h5678);    // bad, all mask bits
        send_frame(8'h5C, 16'h4321, 16'h8765);          // bad, good bit plus errors
        drain();

        // widest span, sealed offset, highest density
        apply_setting(PA_MOST_NEG, PA_MOST_POS, MODE_SEALED, 11'h7FF);
        send_frame(STATUS_GOOD, 16'd0, 16'h0010);
        send_frame(STATUS_GOOD, 16'hFFFF, 16'hFFF0);
        send_frame(8'h80, 16'd30000, 16'd30000);        // bad
        send_frame(STATUS_GOOD, 16'd16385, 16'h7FFF);
        drain();

        // inverted span, absolute mode, density 1: depth saturates both ways
        apply_setting(PA_MOST_POS, PA_MOST_NEG, MODE_ABS_A, 11'd1);
        send_frame(STATUS_GOOD, 16'd0, 16'h1234);
        send_frame(STATUS_GOOD, 16'hFFFF, 16'h4321);
        send_frame(STATUS_GOOD, 16'd16383, 16'h0001);
        send_frame(8'h04, 16'hFFFF, 16'hFFFF);          // bad
        drain();

        // zero density gives zero depth
        apply_setting(CFG_P_W'(-100000000), CFG_P_W'(100000000), MODE_ABS_B, 11'd0);
        send_frame(STATUS_GOOD, 16'd49152, 16'h9000);
        send_frame(STATUS_GOOD, 16'd1, 16'h0100);
        send_frame(8'h08, 16'd5, 16'd5);                // bad
        drain();

        // --- random phases ---
        // 6: no idling on either side; 7: long receiver hold-off
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: apply_setting('0, CFG_P_W'(1000000), MODE_VENTED, 11'd1029);
                1: apply_setting(PA_MOST_NEG, PA_MOST_POS, MODE_SEALED, 11'h7FF);
                2: apply_setting(PA_MOST_POS, PA_MOST_NEG, MODE_ABS_A, 11'd1);
                3: apply_setting(CFG_P_W'(-100000000), CFG_P_W'(100000000),
                                 MODE_ABS_B, 11'd0);
                default: apply_random_setting();
            endcase
            idle_on = (phase != 6);
            if (phase == 7)
                stall_req = 1'b1;
            repeat (180) send_random_frame();
            drain();
        end

        // tail: let any stray word show up before the verdict
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/psfc_pkg.sv
sv/psfc_div.sv
sv/pressure_sensor_frame_convert_core.sv
sv/psfc_checker.sv
tb/psfc_checker.sv
tb/tb.sv
